// ===== rtl/core/m4vt_pkg.sv =====
// m4vt_pkg: payload types, register indexes and float32 helpers for the
// matrix4x4_vector_transform block. No dependencies.
`timescale 1ns / 1ps
package m4vt_pkg;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  // Register stages from input acceptance to result: multiply 3, three adds of 3
  localparam int unsigned PipeDepth = 12;
  localparam logic [31:0] CanonNan  = 32'h7FC0_0000;
  localparam logic [31:0] PosInf    = 32'h7F80_0000;

  // Identity matrix, two elements per register
  localparam logic [63:0] RstRow0L = 64'h0000_0000_3F80_0000;
  localparam logic [63:0] RstRow0R = 64'h0;
  localparam logic [63:0] RstRow1L = 64'h3F80_0000_0000_0000;
  localparam logic [63:0] RstRow1R = 64'h0;
  localparam logic [63:0] RstRow2L = 64'h0;
  localparam logic [63:0] RstRow2R = 64'h0000_0000_3F80_0000;
  localparam logic [63:0] RstRow3L = 64'h0;
  localparam logic [63:0] RstRow3R = 64'h3F80_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_ROW0_LEFT  = 3'd0,
    REG_ROW0_RIGHT = 3'd1,
    REG_ROW1_LEFT  = 3'd2,
    REG_ROW1_RIGHT = 3'd3,
    REG_ROW2_LEFT  = 3'd4,
    REG_ROW2_RIGHT = 3'd5,
    REG_ROW3_LEFT  = 3'd6,
    REG_ROW3_RIGHT = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] vec_w;
    logic [31:0] vec_z;
    logic [31:0] vec_y;
    logic [31:0] vec_x;
  } vec_in_t;

  typedef struct packed {
    logic [31:0] out_w;
    logic [31:0] out_z;
    logic [31:0] out_y;
    logic [31:0] out_x;
  } vec_out_t;

  // Unpacked operand: value = (-1)^sgn * man * 2^(exp-150), man has hidden bit
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sgn;
    logic signed [9:0] exp;
    logic [23:0] man;
  } fop_t;

  function automatic fop_t f_unpack(input logic [31:0] b);
    fop_t r;
    r.sgn  = b[31];
    r.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    r.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    r.zero = (b[30:0] == 31'd0);
    if (b[30:23] == 8'd0) begin
      r.exp = 10'sd1;
      r.man = {1'b0, b[22:0]};
    end else begin
      r.exp = $signed({2'b00, b[30:23]});
      r.man = {1'b1, b[22:0]};
    end
    return r;
  endfunction

  // Count leading zeros of a 50-bit word
  function automatic logic [5:0] f_clz50(input logic [49:0] v);
    logic [5:0] n;
    logic       hit;
    n   = 6'd50;
    hit = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 6'(49 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Round and pack a magnitude: value = mag * 2^(e - 150 - 26), mag 50 bits
  // with leading one at bit 49 (or zero). Sticky is folded in bit 0.
  function automatic logic [31:0] f_round(input logic s, input logic signed [11:0] e,
                                          input logic [49:0] mag);
    logic [49:0]  m;
    logic signed [11:0] be;
    logic [11:0]  sh;
    logic [49:0]  shd;
    logic         stk;
    logic [24:0]  q;
    logic         g, rb;
    logic [25:0]  qr;
    logic [31:0]  r;
    m   = mag;
    // biased exponent if leading bit at 49 becomes hidden bit
    be  = e;
    stk = 1'b0;
    shd = m;
    if (be < 12'sd1) begin
      sh = 12'(12'sd1 - be);
      if (sh > 12'd50) begin
        stk = |m;
        shd = '0;
      end else begin
        stk = |(m & ((50'd1 << sh) - 50'd1));
        shd = m >> sh;
      end
      be = 12'sd0;
    end
    // shd[49:26] is the 24-bit significand, [25] guard, rest sticky
    q   = {1'b0, shd[49:26]};
    g   = shd[25];
    rb  = stk | (|shd[24:0]);
    qr  = {1'b0, q} + 26'((g && (rb || q[0])) ? 1 : 0);
    if (be == 12'sd0) begin
      // subnormal; a carry into bit 23 makes it the smallest normal
      r = {s, 7'd0, qr[23], qr[22:0]};
    end else if (qr[24]) begin
      be = be + 12'sd1;
      if (be >= 12'sd255) r = {s, PosInf[30:0]};
      else r = {s, be[7:0], qr[23:1]};
    end else begin
      if (be >= 12'sd255) r = {s, PosInf[30:0]};
      else r = {s, be[7:0], qr[22:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/m4vt_fadd.sv =====
// m4vt_fadd: three-stage float32 adder, round to nearest even.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps
module m4vt_fadd (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] sum_o
);
  import m4vt_pkg::*;

  // Stage 1: unpack, order by magnitude, align smaller operand
  fop_t        ua, ub, big, sml;
  logic [10:0] dexp;
  logic [49:0] bigm, smlm;
  logic        sstk;
  logic [49:0] smlsh;
  logic [31:0] spec_d;
  logic        spec_v_d;

  always_comb begin
    ua = f_unpack(a_i);
    ub = f_unpack(b_i);
    if ({ua.exp, ua.man} >= {ub.exp, ub.man}) begin
      big = ua; sml = ub;
    end else begin
      big = ub; sml = ua;
    end
    dexp  = 11'(big.exp - sml.exp);
    bigm  = {big.man, 26'd0};
    smlm  = {sml.man, 26'd0};
    if (dexp > 11'd49) begin
      smlsh = '0;
      sstk  = |smlm;
    end else begin
      smlsh = smlm >> dexp;
      sstk  = |(smlm & ((50'd1 << dexp) - 50'd1));
    end
    smlsh[0] = smlsh[0] | sstk;
    spec_v_d = 1'b1;
    spec_d   = CanonNan;
    if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sgn != ub.sgn))) spec_d = CanonNan;
    else if (ua.inf) spec_d = a_i;
    else if (ub.inf) spec_d = b_i;
    else if (ua.zero && ub.zero) spec_d = {ua.sgn & ub.sgn, 31'd0};
    else spec_v_d = 1'b0;
  end

  logic [49:0]        bigm_q, smlm_q;
  logic               bsgn_q, sub_q, spec_v_q;
  logic signed [9:0]  bexp_q;
  logic [31:0]        spec_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bigm_q   <= bigm;
      smlm_q   <= smlsh;
      bsgn_q   <= big.sgn;
      sub_q    <= big.sgn ^ sml.sgn;
      bexp_q   <= big.exp;
      spec_v_q <= spec_v_d;
      spec_q   <= spec_d;
    end
  end

  // Stage 2: add or subtract magnitudes, count leading zeros below bit 50
  logic [50:0] raw;
  logic [5:0]  lz;
  always_comb begin
    raw = sub_q ? ({1'b0, bigm_q} - {1'b0, smlm_q}) : ({1'b0, bigm_q} + {1'b0, smlm_q});
    lz  = f_clz50(raw[49:0]);
  end

  logic [50:0]       raw_q;
  logic [5:0]        lz_q;
  logic              sgn2_q, spec_v2_q;
  logic signed [9:0] exp2_q;
  logic [31:0]       spec2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      raw_q     <= raw;
      lz_q      <= lz;
      sgn2_q    <= bsgn_q;
      exp2_q    <= bexp_q;
      spec_v2_q <= spec_v_q;
      spec2_q   <= spec_q;
    end
  end

  // Stage 3: normalize and round. Leading bit at raw[50] means exp+1.
  logic [49:0]        nm;
  logic signed [11:0] ne;
  logic [31:0]        res;
  always_comb begin
    if (raw_q[50]) begin
      nm = {raw_q[50:2], raw_q[1] | raw_q[0]};
      ne = 12'(exp2_q) + 12'sd1;
    end else begin
      // leading one to bit 49; rounding denormalizes when ne drops below 1
      nm = raw_q[49:0] << lz_q;
      ne = 12'(exp2_q) - $signed({6'd0, lz_q});
    end
    if (spec_v2_q) res = spec2_q;
    else if (raw_q == 51'd0) res = 32'd0;
    else res = f_round(sgn2_q, ne, nm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) sum_o <= res;
  end

endmodule

// ===== rtl/core/m4vt_fmul.sv =====
// m4vt_fmul: three-stage float32 multiplier, round to nearest even.
// Depends on m4vt_pkg.
`timescale 1ns / 1ps
module m4vt_fmul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] prod_o
);
  import m4vt_pkg::*;

  // Stage 1: unpack and register operands
  fop_t ua, ub;
  logic [31:0] spec_d;
  logic        spec_v_d;
  always_comb begin
    ua = f_unpack(a_i);
    ub = f_unpack(b_i);
    spec_v_d = 1'b1;
    spec_d   = CanonNan;
    if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ub.inf && ua.zero)) spec_d = CanonNan;
    else if (ua.inf || ub.inf) spec_d = {ua.sgn ^ ub.sgn, PosInf[30:0]};
    else if (ua.zero || ub.zero) spec_d = {ua.sgn ^ ub.sgn, 31'd0};
    else spec_v_d = 1'b0;
  end

  logic [23:0]        ma_q, mb_q;
  logic signed [11:0] e1_q;
  logic               s1_q, sv1_q;
  logic [31:0]        sp1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q  <= ua.man;
      mb_q  <= ub.man;
      e1_q  <= 12'(ua.exp) + 12'(ub.exp) - 12'sd126;
      s1_q  <= ua.sgn ^ ub.sgn;
      sv1_q <= spec_v_d;
      sp1_q <= spec_d;
    end
  end

  // Stage 2: 24x24 multiply
  logic [47:0]        p_q;
  logic signed [11:0] e2_q;
  logic               s2_q, sv2_q;
  logic [31:0]        sp2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q   <= ma_q * mb_q;
      e2_q  <= e1_q;
      s2_q  <= s1_q;
      sv2_q <= sv1_q;
      sp2_q <= sp1_q;
    end
  end

  // Stage 3: normalize (product value = p * 2^(e2-150-24)) and round
  logic [5:0]         lz;
  logic [49:0]        nm;
  logic signed [11:0] ne;
  logic [31:0]        res;
  always_comb begin
    lz = f_clz50({p_q, 2'b00});
    // with p at bits 49..2, leading bit at 49 has exponent e2; rounding
    // denormalizes when ne drops below 1
    nm = {p_q, 2'b00} << lz;
    ne = e2_q - $signed({6'd0, lz});
    if (sv2_q) res = sp2_q;
    else res = f_round(s2_q, ne, nm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) prod_o <= res;
  end

endmodule

// ===== rtl/core/matrix4x4_vector_transform.sv =====
// matrix4x4_vector_transform: top level, float32 4x4 matrix times vector.
// Depends on m4vt_pkg, m4vt_fmul, m4vt_fadd.
`timescale 1ns / 1ps
//
// Usage:
//   in_valid_i/in_ready_o carry one vector item (vec_x..vec_w, float32 bits).
//   out_valid_o/out_ready_i carry one result item (out_x..out_w), each the
//   dot product of one matrix row with the vector, summed left to right
//   with single rounding after every multiply and add.
//   cfg_valid_i/cfg_ready_o with cfg_idx_i/cfg_data_i write one 64-bit
//   register holding two matrix elements; each 3-bit index names one of the eight.
//   Write configuration only while the pipeline is empty.
// Pipeline: an item passes the registered multiply and then three chained
//   registered adds. Throughput: one item per cycle while the output is not stalled.
// Reset: the matrix returns to identity and the pipeline empties.
// Stall: when out_ready_i is low and the output holds an item, the whole
//   pipeline freezes; in_ready_o drops only then, so nothing is lost.
module matrix4x4_vector_transform (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  m4vt_pkg::vec_in_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output m4vt_pkg::vec_out_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [m4vt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [m4vt_pkg::CfgDataW-1:0] cfg_data_i
);
  import m4vt_pkg::*;

  // Configuration registers
  logic [CfgDataW-1:0] mat_q [NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q[REG_ROW0_LEFT]  <= RstRow0L;
      mat_q[REG_ROW0_RIGHT] <= RstRow0R;
      mat_q[REG_ROW1_LEFT]  <= RstRow1L;
      mat_q[REG_ROW1_RIGHT] <= RstRow1R;
      mat_q[REG_ROW2_LEFT]  <= RstRow2L;
      mat_q[REG_ROW2_RIGHT] <= RstRow2R;
      mat_q[REG_ROW3_LEFT]  <= RstRow3L;
      mat_q[REG_ROW3_RIGHT] <= RstRow3R;
    end else if (cfg_valid_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Pipeline advance: stalls only when the output holds an untaken item
  logic en;
  logic [PipeDepth-1:0] vld_q;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
    end
  end

  // Vector components in element order
  logic [31:0] vcomp [4];
  assign vcomp[0] = in_data_i.vec_x;
  assign vcomp[1] = in_data_i.vec_y;
  assign vcomp[2] = in_data_i.vec_z;
  assign vcomp[3] = in_data_i.vec_w;

  logic [31:0] prod [4][4];
  logic [31:0] dly2_q [4][3];
  logic [31:0] dly3_q [4][6];
  logic [31:0] s1 [4];
  logic [31:0] s2 [4];
  logic [31:0] s3 [4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    // Four products of row r
    for (genvar c = 0; c < 4; c++) begin : g_col
      logic [31:0] elem;
      assign elem = (c < 2) ? mat_q[2*r][32*(c%2) +: 32] : mat_q[2*r+1][32*(c%2) +: 32];
      m4vt_fmul u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (elem),
        .b_i   (vcomp[c]),
        .prod_o(prod[r][c])
      );
    end

    // Delay lines keep later products aligned with the running sum
    always_ff @(posedge clk_i) begin
      if (en) begin
        dly2_q[r][0] <= prod[r][2];
        dly2_q[r][1] <= dly2_q[r][0];
        dly2_q[r][2] <= dly2_q[r][1];
        dly3_q[r][0] <= prod[r][3];
        for (int k = 1; k < 6; k++) dly3_q[r][k] <= dly3_q[r][k-1];
      end
    end

    m4vt_fadd u_add0 (.clk_i(clk_i), .en_i(en), .a_i(prod[r][0]), .b_i(prod[r][1]),
                      .sum_o(s1[r]));
    m4vt_fadd u_add1 (.clk_i(clk_i), .en_i(en), .a_i(s1[r]), .b_i(dly2_q[r][2]),
                      .sum_o(s2[r]));
    m4vt_fadd u_add2 (.clk_i(clk_i), .en_i(en), .a_i(s2[r]), .b_i(dly3_q[r][5]),
                      .sum_o(s3[r]));
  end

  assign out_data_o.out_x = s3[0];
  assign out_data_o.out_y = s3[1];
  assign out_data_o.out_z = s3[2];
  assign out_data_o.out_w = s3[3];

  // Checks
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

// ===== dv/matrix4x4_vector_transform_test.sv =====
// matrix4x4_vector_transform_test: self-checking bench for the float32 4x4
// matrix-vector block. Depends on m4vt_pkg and the matrix4x4_vector_transform RTL.
`timescale 1ns / 1ps
module matrix4x4_vector_transform_test;
  import m4vt_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  vec_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  vec_out_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // matrix shadow, element k of row-major order
  logic [31:0] mat_elem [16];
  vec_out_t    expected_vecs [$];
  int          err_count;
  int          vec_count;
  int          cfg_count;
  int          send_idle;
  int          recv_idle;

  matrix4x4_vector_transform uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------- float32 arithmetic, round to nearest even ----------------

  // Round m * 2^ex to single precision with sign s
  function automatic logic [31:0] fp_round(input logic s, input int ex, input logic [63:0] m);
    int          p;
    int          be;
    int          sh;
    logic [63:0] q;
    logic        g;
    logic        st;
    if (m == 64'd0) return {s, 31'd0};
    p = 63;
    while (!m[p]) p--;
    be = p + ex + 127;
    sh = (be >= 1) ? p - 23 : -(ex + 149);
    if (sh <= 0) begin
      q  = m << (-sh);
      g  = 1'b0;
      st = 1'b0;
    end else if (sh > 64) begin
      q  = 64'd0;
      g  = 1'b0;
      st = 1'b1;
    end else begin
      q  = (sh == 64) ? 64'd0 : m >> sh;
      g  = m[sh-1];
      st = |(m & ((64'd1 << (sh - 1)) - 64'd1));
    end
    if (g && (st || q[0])) q = q + 64'd1;
    // subnormal; a carry into bit 23 lands on the smallest normal
    if (be < 1) return {s, q[30:0]};
    if (q[24]) begin
      q  = q >> 1;
      be = be + 1;
    end
    if (be >= 255) return {s, PosInf[30:0]};
    return {s, be[7:0], q[22:0]};
  endfunction

  // Significand and exponent of a finite value: value = m * 2^ex
  function automatic void fp_split(input logic [31:0] b, output logic [63:0] m, output int ex);
    if (b[30:23] == 8'd0) begin
      m  = {41'd0, b[22:0]};
      ex = -149;
    end else begin
      m  = {40'd0, 1'b1, b[22:0]};
      ex = int'(b[30:23]) - 150;
    end
  endfunction

  function automatic logic fp_is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic fp_is_inf(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [63:0] ma;
    logic [63:0] mb;
    int          ea;
    int          eb;
    s = a[31] ^ b[31];
    if (fp_is_nan(a) || fp_is_nan(b)) return CanonNan;
    if ((fp_is_inf(a) && b[30:0] == 31'd0) || (fp_is_inf(b) && a[30:0] == 31'd0))
      return CanonNan;
    if (fp_is_inf(a) || fp_is_inf(b)) return {s, PosInf[30:0]};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    return fp_round(s, ea + eb, ma * mb);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    logic [63:0] ma;
    logic [63:0] mb;
    int          ea;
    int          eb;
    int          d;
    int          ex;
    if (fp_is_nan(a) || fp_is_nan(b)) return CanonNan;
    if (fp_is_inf(a) && fp_is_inf(b)) return (a[31] == b[31]) ? a : CanonNan;
    if (fp_is_inf(a)) return a;
    if (fp_is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (b[30:0] == 31'd0) return a;
    if (a[30:0] == 31'd0) return b;
    // keep the larger exponent in a
    if (b[30:23] > a[30:23]) begin
      t = a;
      a = b;
      b = t;
    end
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    d = ea - eb;
    if (d <= 38) begin
      ma = ma << d;
      ex = eb;
    end else begin
      // far-off operand only matters as a sticky bit
      ma = ma << 3;
      mb = 64'd1;
      ex = ea - 3;
    end
    if (a[31] == b[31]) return fp_round(a[31], ex, ma + mb);
    if (ma > mb) return fp_round(a[31], ex, ma - mb);
    if (mb > ma) return fp_round(b[31], ex, mb - ma);
    return 32'd0;
  endfunction

  // One matrix row dot the vector, summed left to right
  function automatic logic [31:0] row_dot(input int r, input vec_in_t v);
    logic [31:0] acc;
    acc = fp_add(fp_mul(mat_elem[4*r], v.vec_x), fp_mul(mat_elem[4*r+1], v.vec_y));
    acc = fp_add(acc, fp_mul(mat_elem[4*r+2], v.vec_z));
    acc = fp_add(acc, fp_mul(mat_elem[4*r+3], v.vec_w));
    return fp_is_nan(acc) ? CanonNan : acc;
  endfunction

  function automatic vec_out_t transform_vec(input vec_in_t v);
    vec_out_t o;
    o.out_x = row_dot(0, v);
    o.out_y = row_dot(1, v);
    o.out_z = row_dot(2, v);
    o.out_w = row_dot(3, v);
    return o;
  endfunction

  // ---------------- stimulus helpers ----------------

  // Float bit patterns weighted toward moderate values, with specials mixed in
  function automatic logic [31:0] rand_float();
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) return $urandom;
    if (sel < 23) return {1'($urandom_range(1)), 31'd0};
    if (sel < 25) return {1'($urandom_range(1)), PosInf[30:0]};
    if (sel < 27) return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(32'h7FFFFF, 1))};
    if (sel < 31) return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
    if (sel < 33) return {1'($urandom_range(1)), 8'hFE, 23'($urandom)};
    return {1'($urandom_range(1)), 8'($urandom_range(147, 107)), 23'($urandom)};
  endfunction

  task automatic send_vec(input vec_in_t v);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
    expected_vecs.push_back(transform_vec(v));
    vec_count++;
  endtask

  task automatic send_xyzw(input logic [31:0] x, y, z, w);
    vec_in_t v;
    v.vec_x = x;
    v.vec_y = y;
    v.vec_z = z;
    v.vec_w = w;
    send_vec(v);
  endtask

  // Register write; valid stays high for a following write
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    mat_elem[2*idx]   = value[31:0];
    mat_elem[2*idx+1] = value[63:32];
    cfg_count++;
  endtask

  // Let the pipeline empty before touching the matrix
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_vecs.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic load_matrix(input logic [31:0] m [16]);
    drain();
    for (int i = 0; i < 8; i++) write_reg(reg_idx_e'(i), {m[2*i+1], m[2*i]});
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------- result checker ----------------

  always @(posedge clk_i) begin
    vec_out_t exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_vecs.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data_o);
        err_count++;
      end else begin
        exp_v = expected_vecs.pop_front();
        if (out_data_o.out_x !== exp_v.out_x) begin
          $display("%0t: out_x expected %h actual %h", $time, exp_v.out_x, out_data_o.out_x);
          err_count++;
        end
        if (out_data_o.out_y !== exp_v.out_y) begin
          $display("%0t: out_y expected %h actual %h", $time, exp_v.out_y, out_data_o.out_y);
          err_count++;
        end
        if (out_data_o.out_z !== exp_v.out_z) begin
          $display("%0t: out_z expected %h actual %h", $time, exp_v.out_z, out_data_o.out_z);
          err_count++;
        end
        if (out_data_o.out_w !== exp_v.out_w) begin
          $display("%0t: out_w expected %h actual %h", $time, exp_v.out_w, out_data_o.out_w);
          err_count++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // ---------------- tests ----------------

  // Identity matrix after reset, field extremes and specials
  task automatic test_identity();
    send_xyzw(32'h0000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7F7F_FFFF);
    send_xyzw(32'h0000_0001, 32'h8000_0001, 32'h007F_FFFF, 32'h0080_0000);
    send_xyzw(PosInf, {1'b1, PosInf[30:0]}, 32'h7FC0_0001, 32'hFF80_0001);
    send_xyzw(32'h3F80_0000, 32'hBF80_0000, 32'h4049_0FDB, 32'hFF7F_FFFF);
    send_xyzw(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h8000_0000);
  endtask

  // Overflow, inf * 0, inf - inf, cancellation and subnormal products
  task automatic test_special_cases();
    logic [31:0] m [16];
    m = '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 32'h0000_0000,
          32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000,
          32'h0080_0000, 32'h3F00_0000, 32'h0000_0001, 32'h3400_0000,
          32'h7F80_0000, 32'hFF80_0000, 32'hFFFF_FFFF, 32'h8000_0000};
    load_matrix(m);
    send_xyzw(32'h4000_0000, 32'h4000_0000, PosInf, 32'h3F80_0000);
    send_xyzw(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
    send_xyzw(32'h3F80_0001, 32'h3F80_0000, 32'h3380_0000, 32'h3380_0001);
    send_xyzw(32'h0000_0000, 32'h0000_0003, 32'h3F00_0000, 32'h0000_0000);
    send_xyzw(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h8000_0000, 32'h4B00_0001);
    send_xyzw(32'h0080_0001, 32'h3F80_0000, 32'h3F00_0000, 32'h0000_0001);
  endtask

  // Random matrices and vectors under the current idle setting
  task automatic test_random(input int n_mats, input int per_mat);
    logic [31:0] m [16];
    vec_in_t     v;
    for (int k = 0; k < n_mats; k++) begin
      for (int i = 0; i < 16; i++) m[i] = rand_float();
      load_matrix(m);
      for (int j = 0; j < per_mat; j++) begin
        v = {rand_float(), rand_float(), rand_float(), rand_float()};
        // sometimes repeat a component so row terms cancel
        if ($urandom_range(9) == 0) v.vec_y = v.vec_x;
        send_vec(v);
      end
    end
  endtask

  initial begin
    err_count   = 0;
    vec_count   = 0;
    cfg_count   = 0;
    send_idle   = 37;
    recv_idle   = 70;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    mat_elem    = '{32'h3F80_0000, 0, 0, 0, 0, 32'h3F80_0000, 0, 0,
                    0, 0, 32'h3F80_0000, 0, 0, 0, 0, 32'h3F80_0000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity();
    test_special_cases();
    test_random(15, 30);
    send_idle = 70;
    recv_idle = 37;
    test_random(15, 30);
    send_idle = 0;
    recv_idle = 0;
    test_random(15, 30);

    drain();
    $display("Covered %0d vectors over %0d register writes, identity, specials and random",
             vec_count, cfg_count);
    $display("matrices under three idling mixes.");
    if (err_count == 0) begin
      $display("matrix4x4_vector_transform_test: done, clean");
    end else begin
      $display("matrix4x4_vector_transform_test: done, errors");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("matrix4x4_vector_transform_test: done, errors");
    $finish;
  end

endmodule

// ===== matrix4x4_vector_transform.f =====
rtl/core/m4vt_pkg.sv
rtl/core/m4vt_fadd.sv
rtl/core/m4vt_fmul.sv
rtl/core/matrix4x4_vector_transform.sv
dv/matrix4x4_vector_transform_test.sv
